[rtl/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MTB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtb_pkg.sv]
// types and constants of the note to midi bend converter
package mtb_pkg;

  localparam int STEPS_PER_STAGE = 4;
  localparam int PITCH_W = 13;
  localparam int BEND_NUM_W = 21;
  localparam int BEND_W = 14;
  localparam int CFG_AW = 4;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [23:0] VEL_SCALE = 24'd127;
  localparam logic [22:0] NOTE_MAX = 23'd8323072;
  localparam logic [BEND_W-1:0] BEND_CENTER = 14'd8192;
  localparam logic [BEND_W-1:0] BEND_SAT = 14'd16383;

  // floor(x*64/25) by reciprocal: n = 64*(x+2^23)+13, q = (n*R)>>35, result q-OFS
  localparam logic [45:0] DIV25_RECIP = 46'd1374389535;
  localparam logic [29:0] DIV25_ROUND = 30'd13;
  localparam logic [26:0] DIV25_OFS = 27'd21474837;

  localparam logic [4:0] RST_TUNING = 5'd12;
  localparam logic [22:0] RST_OCTAVE = 23'd307200;
  localparam logic [22:0] RST_BASE = 23'd3932160;
  localparam logic [13:0] RST_BEND = 14'd512;

  typedef enum logic [1:0] {
    REG_TUNING = 2'd0,
    REG_OCTAVE = 2'd1,
    REG_BASE   = 2'd2,
    REG_BEND   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  tuning_length;
    logic [22:0] octave_span;
    logic [22:0] base_note;
    logic [13:0] bend_range;
  } cfg_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [6:0]  vel;
  } tim_t;

  function automatic logic [16:0] sat_frac(logic [16:0] f);
    return (f > Q16_ONE) ? Q16_ONE : f;
  endfunction

endpackage

[rtl/mtb_in_if.sv]
// input channel: note and table write transactions
interface mtb_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [12:0] pitch;
  logic [16:0]        delay_fraction;
  logic [16:0]        gate_fraction;
  logic [16:0]        velocity_fraction;
  logic [31:0]        span_offset;
  logic [31:0]        span_count;
  logic [3:0]         table_index;
  logic signed [23:0] table_value;

  modport source (
    output valid, command, pitch, delay_fraction, gate_fraction, velocity_fraction,
    output span_offset, span_count, table_index, table_value,
    input ready
  );
  modport sink (
    input valid, command, pitch, delay_fraction, gate_fraction, velocity_fraction,
    input span_offset, span_count, table_index, table_value,
    output ready
  );
endinterface

[rtl/mtb_out_if.sv]
// output channel: midi note transactions
interface mtb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_sample;
  logic [31:0] stop_sample;
  logic [6:0]  note_number;
  logic [6:0]  midi_velocity;
  logic [13:0] bend_value;

  modport source (
    output valid, start_sample, stop_sample, note_number, midi_velocity, bend_value,
    input ready
  );
  modport sink (
    input valid, start_sample, stop_sample, note_number, midi_velocity, bend_value,
    output ready
  );
endinterface

[rtl/microtonal_note_to_midi_bend.sv]
// top level: scale-step pitch to midi note, pitch bend and timing
//
//   channel  dir  handshake      contents
//   req      in   valid/ready    note or table write transaction
//   rsp      out  valid/ready    start, stop, note, velocity, bend
//   apb      in   psel/penable   four configuration registers
//
// one transaction per cycle while rsp is not stalled, 17 register stages
// the two dividers resolve 4 quotient bits per stage
// table write transactions update the interval table as they enter the table read stage and then vanish
// each stage advances when it is empty or the stage after it advances
// rst clears the valid bits and the configuration registers, the data registers and the table hold no reset
`include "assert_macros.svh"

module microtonal_note_to_midi_bend import mtb_pkg::*; #(
  parameter int MAX_INTERVALS = 16
) (
  input  logic              clk,
  input  logic              rst,
  mtb_in_if.sink            req,
  mtb_out_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LEN_W  = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int D1_STG = (PITCH_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int D2_STG = (BEND_NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int P_D1   = 1;
  localparam int P_RD   = P_D1 + D1_STG;
  localparam int P_CENT = P_RD + 1;
  localparam int P_MUL  = P_CENT + 1;
  localparam int P_QUO  = P_MUL + 1;
  localparam int P_NOTE = P_QUO + 1;
  localparam int P_D2   = P_NOTE + 1;
  localparam int P_OUT  = P_D2 + D2_STG;
  localparam int NSTG   = P_OUT + 1;
  localparam logic [NSTG-1:0] ONES = '1;

  typedef struct packed {
    logic             cmd;
    logic             neg;
    logic [LEN_W-1:0] len;
    logic [3:0]       tidx;
    logic [23:0]      tval;
  } side_t;

  cfg_t cfg;

  mtb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );
  assign pready = 1'b1;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;
  side_t           sd [P_RD];

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = rsp.ready || ((v | ~(ONES << k)) != ONES);
    end
  end
  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          if (k == 0) begin
            v[k] <= req.valid;
          end else if (k == P_RD) begin
            v[k] <= v[k-1] && !sd[P_RD-1].cmd;
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // input stage
  logic [LEN_W-1:0] len_c;
  logic [31:0]      cnt0;
  logic [31:0]      ofs0;
  logic [16:0]      dfr0;
  logic [16:0]      gfr0;
  logic [16:0]      vfr0;
  logic [12:0]      mag0;

  always_comb begin
    if (cfg.tuning_length == 5'd0) begin
      len_c = LEN_W'(1);
    end else if (32'(cfg.tuning_length) > MAX_INTERVALS) begin
      len_c = LEN_W'(MAX_INTERVALS);
    end else begin
      len_c = LEN_W'(cfg.tuning_length);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cnt0       <= req.span_count;
      ofs0       <= req.span_offset;
      dfr0       <= sat_frac(req.delay_fraction);
      gfr0       <= sat_frac(req.gate_fraction);
      vfr0       <= sat_frac(req.velocity_fraction);
      mag0       <= req.pitch[12] ? 13'(-req.pitch) : 13'(req.pitch);
      sd[0].cmd  <= req.command;
      sd[0].neg  <= req.pitch[12];
      sd[0].len  <= len_c;
      sd[0].tidx <= req.table_index;
      sd[0].tval <= req.table_value;
    end
    for (int k = 1; k < P_RD; k++) begin
      if (en[k]) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // timing path
  logic [31:0] dly1;
  logic [31:0] cnt1;
  logic [31:0] ofs1;
  logic [16:0] gfr1;
  logic [6:0]  vel1;
  logic [31:0] start2;
  logic [31:0] len2;
  logic [6:0]  vel2;
  logic [23:0] vel_prod;
  tim_t        tim [3:P_OUT];

  assign vel_prod = 24'(vfr0) * VEL_SCALE;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dly1 <= 32'((64'(cnt0) * 64'(dfr0)) >> 16);
      cnt1 <= cnt0;
      ofs1 <= ofs0;
      gfr1 <= gfr0;
      vel1 <= vel_prod[22:16];
    end
    if (en[2]) begin
      start2 <= ofs1 + dly1;
      len2   <= 32'((64'(cnt1 - dly1) * 64'(gfr1)) >> 16);
      vel2   <= vel1;
    end
    if (en[3]) begin
      tim[3].start <= start2;
      tim[3].stop  <= start2 + len2;
      tim[3].vel   <= vel2;
    end
    for (int k = 4; k <= P_OUT; k++) begin
      if (en[k]) begin
        tim[k] <= tim[k-1];
      end
    end
  end

  // pitch divided by table length
  logic [12:0]      d1_quot;
  logic [LEN_W-1:0] d1_rem;

  mtb_div #(
    .NUM_W (PITCH_W),
    .DEN_W (LEN_W),
    .STEPS (STEPS_PER_STAGE)
  ) u_div_pitch (
    .clk  (clk),
    .en   (en[P_D1 +: D1_STG]),
    .num  (mag0),
    .den  (sd[0].len),
    .quot (d1_quot),
    .rem  (d1_rem)
  );

  // interval table access and octave product
  logic [23:0]        itab [MAX_INTERVALS];
  logic [23:0]        rdata;
  logic               wrap_c;
  logic [IDX_W-1:0]   ridx;
  logic [IDX_W-1:0]   widx;
  logic signed [13:0] quot_s;
  logic signed [23:0] oct_s;
  logic signed [37:0] prod5;
  logic               wrap5;

  assign wrap_c = sd[P_RD-1].neg && (d1_rem != '0);
  assign ridx   = wrap_c ? IDX_W'(sd[P_RD-1].len - d1_rem) : IDX_W'(d1_rem);
  assign widx   = IDX_W'(sd[P_RD-1].tidx);
  assign quot_s = sd[P_RD-1].neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
  assign oct_s  = $signed({1'b0, cfg.octave_span});

  always_ff @(posedge clk) begin
    if (en[P_RD] && v[P_RD-1]) begin
      if (sd[P_RD-1].cmd) begin
        if (32'(sd[P_RD-1].tidx) < MAX_INTERVALS) begin
          itab[widx] <= sd[P_RD-1].tval;
        end
      end
      rdata <= itab[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_RD]) begin
      prod5 <= 38'(quot_s) * 38'(oct_s);
      wrap5 <= wrap_c;
    end
  end

  // cents, clamped and biased for the divide by 25
  logic signed [38:0] cents;
  logic [23:0]        cl;
  logic [29:0]        n6;

  always_comb begin
    cents = 39'(prod5) + 39'($signed(rdata)) - (wrap5 ? 39'(oct_s) : 39'sd0);
    if (cents > 39'sd8388607) begin
      cl = 24'h7FFFFF;
    end else if (cents < -39'sd8388608) begin
      cl = 24'h800000;
    end else begin
      cl = cents[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_CENT]) begin
      n6 <= {cl ^ 24'h800000, 6'b0} + DIV25_ROUND;
    end
  end

  // reciprocal multiply in two partial products
  logic [45:0] ph7;
  logic [45:0] pl7;
  logic [60:0] sum8;
  logic [25:0] q8;

  always_ff @(posedge clk) begin
    if (en[P_MUL]) begin
      ph7 <= 46'(n6[29:15]) * DIV25_RECIP;
      pl7 <= 46'(n6[14:0]) * DIV25_RECIP;
    end
  end

  assign sum8 = {ph7, 15'b0} + 61'(pl7);

  always_ff @(posedge clk) begin
    if (en[P_QUO]) begin
      q8 <= sum8[60:35];
    end
  end

  // note clamp and bend dividend
  logic signed [26:0] note_s;
  logic [22:0]        note_c;
  logic [20:0]        num9;
  logic [13:0]        den9;
  logic [6:0]         whole [P_NOTE:P_OUT];

  always_comb begin
    note_s = $signed(27'(cfg.base_note) + 27'(q8) - DIV25_OFS);
    if (note_s < 27'sd0) begin
      note_c = '0;
    end else if (note_s > $signed(27'(NOTE_MAX))) begin
      note_c = NOTE_MAX;
    end else begin
      note_c = note_s[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[P_NOTE]) begin
      whole[P_NOTE] <= note_c[22:16];
      num9          <= {note_c[15:0], 5'b0};
      den9          <= (cfg.bend_range == '0) ? 14'd1 : cfg.bend_range;
    end
    for (int k = P_NOTE + 1; k <= P_OUT; k++) begin
      if (en[k]) begin
        whole[k] <= whole[k-1];
      end
    end
  end

  logic [20:0] d2_quot;
  logic [13:0] d2_rem;

  mtb_div #(
    .NUM_W (BEND_NUM_W),
    .DEN_W (BEND_W),
    .STEPS (STEPS_PER_STAGE)
  ) u_div_bend (
    .clk  (clk),
    .en   (en[P_D2 +: D2_STG]),
    .num  (num9),
    .den  (den9),
    .quot (d2_quot),
    .rem  (d2_rem)
  );

  // output stage
  logic [13:0] bend_q;

  always_ff @(posedge clk) begin
    if (en[P_OUT]) begin
      bend_q <= (d2_quot[20:13] != '0 && d2_rem == d2_rem) ? BEND_SAT
                                                            : {1'b1, d2_quot[12:0]};
    end
  end

  assign rsp.valid         = v[P_OUT];
  assign rsp.start_sample  = tim[P_OUT].start;
  assign rsp.stop_sample   = tim[P_OUT].stop;
  assign rsp.midi_velocity = tim[P_OUT].vel;
  assign rsp.note_number   = whole[P_OUT];
  assign rsp.bend_value    = bend_q;

  `MTB_ASSERT_NXT(a_write_leaves, clk, rst, en[P_RD] && v[P_RD-1] && sd[P_RD-1].cmd, !v[P_RD], "table write reached the note path")
  `MTB_ASSERT_IMP(a_top_note_center, clk, rst, rsp.valid && rsp.note_number == 7'd127, rsp.bend_value == BEND_CENTER, "top note carries a bend")
  `MTB_ASSERT_IMP(a_blocked_full, clk, rst, !req.ready, v == ONES, "input blocked with a free stage")

endmodule

[rtl/mtb_div.sv]
// pipelined restoring divider, STEPS quotient bits per stage
module mtb_div #(
  parameter int NUM_W = 13,
  parameter int DEN_W = 7,
  parameter int STEPS = 4,
  parameter int NSTG  = (NUM_W + STEPS - 1) / STEPS
) (
  input  logic             clk,
  input  logic [NSTG-1:0]  en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  logic [NUM_W-1:0] sh [NSTG];
  logic [DEN_W-1:0] rm [NSTG];
  logic [DEN_W-1:0] dv [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [NUM_W-1:0] sh_next;
    logic [DEN_W-1:0] rm_next;
    logic [NUM_W-1:0] sh_in;
    logic [DEN_W-1:0] rm_in;
    logic [DEN_W-1:0] dv_in;

    if (k == 0) begin : g_first
      assign sh_in = num;
      assign rm_in = '0;
      assign dv_in = den;
    end else begin : g_rest
      assign sh_in = sh[k-1];
      assign rm_in = rm[k-1];
      assign dv_in = dv[k-1];
    end

    always_comb begin
      logic [DEN_W:0]   t;
      logic [NUM_W-1:0] s;
      logic [DEN_W-1:0] r;
      s = sh_in;
      r = rm_in;
      t = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (k * STEPS + j < NUM_W) begin
          t = {r, s[NUM_W-1]};
          s = {s[NUM_W-2:0], 1'b0};
          if (t >= {1'b0, dv_in}) begin
            t = t - {1'b0, dv_in};
            s[0] = 1'b1;
          end
          r = t[DEN_W-1:0];
        end
      end
      sh_next = s;
      rm_next = r;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        sh[k] <= sh_next;
        rm[k] <= rm_next;
        dv[k] <= dv_in;
      end
    end
  end

  assign quot = sh[NSTG-1];
  assign rem  = rm[NSTG-1];

endmodule

[rtl/mtb_cfg.sv]
// apb configuration registers
module mtb_cfg import mtb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  assign idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tuning_length <= RST_TUNING;
      cfg.octave_span   <= RST_OCTAVE;
      cfg.base_note     <= RST_BASE;
      cfg.bend_range    <= RST_BEND;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_TUNING: cfg.tuning_length <= pwdata[4:0];
        REG_OCTAVE: cfg.octave_span   <= pwdata[22:0];
        REG_BASE:   cfg.base_note     <= pwdata[22:0];
        REG_BEND:   cfg.bend_range    <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TUNING: prdata = 32'(cfg.tuning_length);
      REG_OCTAVE: prdata = 32'(cfg.octave_span);
      REG_BASE:   prdata = 32'(cfg.base_note);
      REG_BEND:   prdata = 32'(cfg.bend_range);
      default:    prdata = '0;
    endcase
  end

endmodule

[test/tb.sv]
// testbench for the microtonal note to midi bend converter
module tb;
  import mtb_pkg::*;

  typedef struct {
    bit                 cmd;
    logic signed [12:0] pitch;
    logic [16:0]        dfr;
    logic [16:0]        gfr;
    logic [16:0]        vfr;
    logic [31:0]        off;
    logic [31:0]        cnt;
    logic [3:0]         idx;
    logic signed [23:0] val;
  } note_txn_t;

  typedef struct {
    logic [31:0] start;
    logic [31:0] stop;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [13:0] bend;
  } midi_rsp_t;

  typedef struct {
    note_txn_t txn;
    bit        typed;
    midi_rsp_t rsp;
  } stim_row_t;

  localparam int TABLE_DEPTH = 16;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 24;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  mtb_in_if  in_if();
  mtb_out_if out_if();

  microtonal_note_to_midi_bend uut (
    .clk(clk), .rst(rst), .req(in_if), .rsp(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [4:0]         sh_len;
  logic [22:0]        sh_oct;
  logic [22:0]        sh_base;
  logic [13:0]        sh_bend;
  logic signed [23:0] interval_shadow [TABLE_DEPTH];

  midi_rsp_t pending_notes[$];
  int        errors;
  int        cycles;
  int        idle_pct;
  int        stall_pct;
  stim_row_t rows [25];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic midi_rsp_t predict_note(note_txn_t t);
    midi_rsp_t r;
    longint len, p, q, rm, iv, c, x, fd, n, fr, rng, b, d, g, v, dly, lng;
    len = (sh_len == 0) ? 1 : ((sh_len > TABLE_DEPTH) ? TABLE_DEPTH : sh_len);
    p = longint'(t.pitch);
    q = p / len;
    rm = p % len;
    if (rm < 0) iv = longint'(interval_shadow[rm + len]) - longint'(sh_oct);
    else iv = longint'(interval_shadow[rm]);
    c = q * longint'(sh_oct) + iv;
    x = c * 256;
    fd = x / 100;
    if (x % 100 != 0 && x < 0) fd = fd - 1;
    n = longint'(sh_base) + fd;
    if (n < 0) n = 0;
    if (n > 127 * 65536) n = 127 * 65536;
    fr = n & 64'hFFFF;
    rng = (sh_bend == 0) ? 1 : longint'(sh_bend);
    b = 8192 + (fr * 32) / rng;
    if (b > 16383) b = 16383;
    d = (t.dfr > 65536) ? 65536 : t.dfr;
    g = (t.gfr > 65536) ? 65536 : t.gfr;
    v = (t.vfr > 65536) ? 65536 : t.vfr;
    dly = (longint'(t.cnt) * d) >>> 16;
    lng = ((longint'(t.cnt) - dly) * g) >>> 16;
    r.start = t.off + dly[31:0];
    r.stop = r.start + lng[31:0];
    r.note = n[22:16];
    r.vel = 7'((v * 127) >>> 16);
    r.bend = b[13:0];
    return r;
  endfunction

  function automatic stim_row_t row_wr(int i, int v);
    stim_row_t s;
    s = '{default: '0};
    s.txn.cmd = 1'b1;
    s.txn.idx = 4'(i);
    s.txn.val = 24'(v);
    return s;
  endfunction

  function automatic stim_row_t row_cv(int p, int d, int g, int v, logic [31:0] o,
                                       logic [31:0] c);
    stim_row_t s;
    s = '{default: '0};
    s.txn.pitch = 13'(p);
    s.txn.dfr = 17'(d);
    s.txn.gfr = 17'(g);
    s.txn.vfr = 17'(v);
    s.txn.off = o;
    s.txn.cnt = c;
    return s;
  endfunction

  function automatic stim_row_t row_typed(stim_row_t s, midi_rsp_t r);
    s.typed = 1'b1;
    s.rsp = r;
    return s;
  endfunction

  function automatic logic [16:0] rand_frac();
    if ($urandom_range(4) == 0) return 17'($urandom_range(131071));
    return 17'($urandom_range(65536));
  endfunction

  function automatic note_txn_t rand_txn();
    note_txn_t t;
    t.cmd = ($urandom_range(9) == 0);
    t.idx = 4'($urandom);
    t.val = 24'($urandom);
    if ($urandom_range(1)) t.pitch = 13'($urandom);
    else t.pitch = 13'($urandom_range(80) - 40);
    t.dfr = rand_frac();
    t.gfr = rand_frac();
    t.vfr = rand_frac();
    t.off = $urandom;
    t.cnt = $urandom_range(3) == 0 ? $urandom_range(300) : $urandom;
    return t;
  endfunction

  task automatic send_txn(note_txn_t t, bit typed, midi_rsp_t exp_rsp);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= t.cmd;
    in_if.pitch <= t.pitch;
    in_if.delay_fraction <= t.dfr;
    in_if.gate_fraction <= t.gfr;
    in_if.velocity_fraction <= t.vfr;
    in_if.span_offset <= t.off;
    in_if.span_count <= t.cnt;
    in_if.table_index <= t.idx;
    in_if.table_value <= t.val;
    do @(posedge clk); while (!in_if.ready);
    if (t.cmd) interval_shadow[t.idx] = t.val;
    else if (typed) pending_notes = {pending_notes, exp_rsp};
    else pending_notes = {pending_notes, predict_note(t)};
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_TUNING: sh_len = v[4:0];
      REG_OCTAVE: sh_oct = v[22:0];
      REG_BASE:   sh_base = v[22:0];
      REG_BEND:   sh_bend = v[13:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] l, logic [31:0] o, logic [31:0] b,
                            logic [31:0] r);
    apb_write(REG_TUNING, l);
    apb_write(REG_OCTAVE, o);
    apb_write(REG_BASE, b);
    apb_write(REG_BEND, r);
  endtask

  // check each response transaction against the oldest expected note
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_notes.size() == 0) begin
        $error("unexpected transaction start=%0d", out_if.start_sample);
        errors = errors + 1;
      end else begin
        midi_rsp_t e;
        e = pending_notes.pop_front();
        if (out_if.start_sample !== e.start) begin
          $error("start_sample exp %0d got %0d", e.start, out_if.start_sample);
          errors = errors + 1;
        end
        if (out_if.stop_sample !== e.stop) begin
          $error("stop_sample exp %0d got %0d", e.stop, out_if.stop_sample);
          errors = errors + 1;
        end
        if (out_if.note_number !== e.note) begin
          $error("note_number exp %0d got %0d", e.note, out_if.note_number);
          errors = errors + 1;
        end
        if (out_if.midi_velocity !== e.vel) begin
          $error("midi_velocity exp %0d got %0d", e.vel, out_if.midi_velocity);
          errors = errors + 1;
        end
        if (out_if.bend_value !== e.bend) begin
          $error("bend_value exp %0d got %0d", e.bend, out_if.bend_value);
          errors = errors + 1;
        end
      end
    end
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    midi_rsp_t nr;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    out_if.ready = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = 1'b0;
    in_if.pitch = '0;
    in_if.delay_fraction = '0;
    in_if.gate_fraction = '0;
    in_if.velocity_fraction = '0;
    in_if.span_offset = '0;
    in_if.span_count = '0;
    in_if.table_index = '0;
    in_if.table_value = '0;
    sh_len = RST_TUNING;
    sh_oct = RST_OCTAVE;
    sh_base = RST_BASE;
    sh_bend = RST_BEND;
    foreach (interval_shadow[i]) interval_shadow[i] = '0;

    // semitone steps, value extremes in the top two entries
    for (int i = 0; i < 14; i++) rows[i] = row_wr(i, i * 25600);
    rows[14] = row_wr(14, 8388607);
    rows[15] = row_wr(15, -8388608);
    nr = '{start: 5, stop: 105, note: 60, vel: 127, bend: 8192};
    rows[16] = row_typed(row_cv(0, 0, 65536, 65536, 5, 100), nr);
    nr = '{start: 32'hFFFFFFFE, stop: 32'hFFFFFFFE, note: 0, vel: 0, bend: 8192};
    rows[17] = row_typed(row_cv(-4096, 65536, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF), nr);
    nr = '{start: 1000, stop: 1000, note: 127, vel: 127, bend: 8192};
    rows[18] = row_typed(row_cv(4095, 131071, 131071, 131071, 0, 1000), nr);
    rows[19] = row_cv(-1, 1000, 30000, 40000, 123, 4567);
    rows[20] = row_cv(13, 32768, 32768, 32768, 32'h80000000, 32'h7FFFFFFF);
    rows[21] = row_cv(1, 65535, 65535, 65535, 32'hFFFFFF00, 32'hFFFF);
    rows[22] = row_cv(-13, 7, 65536, 1, 9, 32'hFFFFFFFF);
    rows[23] = row_cv(7, 20000, 50000, 60000, 77, 888888);
    rows[24] = row_cv(11, 65537, 100000, 65537, 1, 2);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_txn(rows[i].txn, rows[i].typed, rows[i].rsp);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      case (ph)
        1: set_config(1, 0, 0, 1);
        2: set_config(16, 23'h7FFFFF, 23'h7FFFFF, 12288);
        3: set_config(0, $urandom_range(400000), $urandom_range(8388607), 0);
        4: set_config(31, $urandom_range(8388607), $urandom_range(8388607), 16383);
        5: set_config($urandom_range(1, 16), $urandom_range(8388607),
                      $urandom_range(8388607), $urandom_range(1, 12288));
        default: ;
      endcase
      for (int n = 0; n < 180; n++) begin
        if (n == 90 && ph == 2) begin
          in_if.valid <= 1'b0;
          while (pending_notes.size() != 0) @(posedge clk);
        end
        send_txn(rand_txn(), 1'b0, nr);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
